// ===== hdl/dwf_pkg.sv =====
// Shared constants and types for the duplicate word filter.
package dwf_pkg;

    localparam int MaxWordLen = 32;
    localparam int MaxWords   = 64;
    localparam int LenW       = $clog2(MaxWordLen + 1);
    localparam int PosW       = $clog2(MaxWordLen);
    localparam int CntW       = $clog2(MaxWords + 1);
    localparam int IdxW       = (MaxWords > 1) ? $clog2(MaxWords) : 1;
    localparam logic [7:0] SepReset = 8'd32;
    localparam int QDepth     = 4;
    localparam int QPtrW      = 2;

    // Classified command from the front part to the back part.
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_LAST = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_EMIT,
        ST_SEP,
        ST_TERM
    } back_state_t;

endpackage

// ===== hdl/dwf_if.sv =====
// Valid/ready channel interfaces for input, output and configuration.
interface dwf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dwf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       word_truncated;
    logic       store_full;
    modport source (output valid, output out_byte, output out_last,
                    output word_truncated, output store_full, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input word_truncated, input store_full, output ready);
endinterface

interface dwf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] separator_char;
    modport source (output valid, output separator_char, input ready);
    modport sink   (input valid, input separator_char, output ready);
endinterface

// ===== hdl/duplicate_word_filter_top.sv =====
// Top level of the duplicate word filter.
//
//  channel   dir  fields
//  in_ch     in   in_byte[7:0], in_last
//  out_ch    out  out_byte[7:0], out_last, word_truncated, store_full
//  cfg_ch    in   separator_char[7:0]
//
// The front accepts one request per cycle while the command queue has room; a request
// marked last holds off the front until the terminator command is queued.
// A word byte is stored in the word buffer by the back part. A word end starts a search:
// each stored word is read and then compared, a final search state closes the search,
// then each byte of a new word is emitted, plus the separator. The terminator emits one byte.
// A four-entry command queue lets the front accept bytes while a word is searched
// or emitted. The output register holds a result while out_ch stalls.
// Reset clears all control state; the word store needs no clearing.
module duplicate_word_filter_top
    import dwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dwf_in_if.sink     in_ch,
    dwf_out_if.source  out_ch,
    dwf_cfg_if.sink    cfg_ch
);

    logic       cmd_pop;
    logic       cmd_valid;
    cmd_t       cmd_head;
    logic [7:0] sep;

    dwf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_ch    (cfg_ch),
        .cmd_pop   (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .sep       (sep)
    );

    dwf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .sep       (sep),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== hdl/dwf_front.sv =====
// Front part: classifies each input request into commands and queues them.
module dwf_front
    import dwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dwf_in_if.sink     in_ch,
    dwf_cfg_if.sink    cfg_ch,
    input  logic       cmd_pop,
    output logic       cmd_valid,
    output cmd_t       cmd_head,
    output logic [7:0] sep
);

    logic [7:0]       sep_reg;
    cmd_t             q_mem [QDepth];
    logic [QPtrW-1:0] wr_reg, rd_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             pend_reg, pend_next;
    cmd_t             push_cmd;
    logic             push, accept;

    assign cfg_ch.ready = 1'b1;
    assign sep          = sep_reg;

    // A byte pushes its own command; with in_last an extra LAST command follows.
    assign in_ch.ready = !pend_reg && (cnt_reg < (QPtrW+1)'(QDepth));
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        push_cmd  = '{kind: CMD_BYTE, data: in_ch.in_byte};
        push      = 1'b0;
        pend_next = pend_reg;
        if (pend_reg)
        begin
            push_cmd = '{kind: CMD_LAST, data: 8'd0};
            push     = (cnt_reg < (QPtrW+1)'(QDepth));
            if (push)
                pend_next = 1'b0;
        end
        else if (accept)
        begin
            push = 1'b1;
            if (in_ch.in_byte == sep_reg)
                push_cmd.kind = CMD_END;
            pend_next = in_ch.in_last;
        end
    end

    assign cmd_valid = (cnt_reg != '0);
    assign cmd_head  = q_mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= SepReset;
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
                sep_reg <= cfg_ch.separator_char;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (cmd_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg  <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(cmd_pop);
            pend_reg <= pend_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < (QPtrW+1)'(QDepth)))
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cnt_reg != '0)
        else $error("command queue underflow");
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.in_last) |=> pend_reg || $past(push))
        else $error("last command not scheduled");
`endif

endmodule

// ===== hdl/dwf_back.sv =====
// Back part: gathers words, searches the seen-word store and emits results.
module dwf_back
    import dwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd_head,
    input  logic [7:0] sep,
    output logic       cmd_pop,
    dwf_out_if.source  out_ch
);

    // Word buffer and store; the store keeps one word per row.
    logic [7:0]              word_mem [MaxWordLen];
    logic [8*MaxWordLen-1:0] seen_mem [MaxWords];
    logic [LenW-1:0]         seen_len [MaxWords];

    back_state_t     state_reg, state_next;
    logic [LenW-1:0] len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] sidx_reg, sidx_next;
    logic [PosW-1:0] epos_reg, epos_next;
    logic            full_reg, full_next;
    logic            last_reg, last_next;
    logic [8*MaxWordLen-1:0] rd_word_reg;
    logic [LenW-1:0]         rd_len_reg;
    logic [8*MaxWordLen-1:0] cur_word;
    logic            match;
    logic            store_wr;
    logic            o_valid_reg;
    logic [7:0]      o_byte_reg;
    logic            o_last_reg, o_trunc_reg, o_full_reg;
    logic            o_load;
    logic [7:0]      o_byte_n;
    logic            o_last_n;
    logic            o_space;

    assign o_space = !o_valid_reg || out_ch.ready;

    always_comb
    begin
        for (int i = 0; i < MaxWordLen; i++)
            cur_word[8*i +: 8] = word_mem[i];
    end

    // Compare only the kept bytes of the fetched entry.
    always_comb
    begin
        match = (rd_len_reg == len_reg);
        for (int i = 0; i < MaxWordLen; i++)
            if (LenW'(i) < len_reg && rd_word_reg[8*i +: 8] != cur_word[8*i +: 8])
                match = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        sidx_next  = sidx_reg;
        epos_next  = epos_reg;
        full_next  = full_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        store_wr   = 1'b0;
        o_load     = 1'b0;
        o_byte_n   = sep;
        o_last_n   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_head.kind)
                        CMD_BYTE:
                        begin
                            if (len_reg < LenW'(MaxWordLen))
                                len_next = len_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        CMD_END, CMD_LAST:
                        begin
                            last_next = (cmd_head.kind == CMD_LAST);
                            sidx_next = '0;
                            if (len_reg == '0)
                            begin
                                ovf_next   = 1'b0;
                                state_next = (cmd_head.kind == CMD_LAST) ? ST_TERM : ST_IDLE;
                            end
                            else
                                state_next = ST_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // Entry sidx_reg is being read this cycle.
                if (sidx_reg >= cnt_reg || sidx_reg >= CntW'(MaxWords))
                begin
                    full_next  = (cnt_reg >= CntW'(MaxWords));
                    store_wr   = (cnt_reg < CntW'(MaxWords));
                    if (store_wr)
                        cnt_next = cnt_reg + 1'b1;
                    epos_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (match)
                begin
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = last_reg ? ST_TERM : ST_IDLE;
                end
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_EMIT:
            begin
                if (o_space)
                begin
                    o_load   = 1'b1;
                    o_byte_n = word_mem[epos_reg];
                    epos_next = epos_reg + 1'b1;
                    if ({1'b0, epos_reg} == LenW'(len_reg - 1'b1))
                        state_next = ST_SEP;
                end
            end
            ST_SEP:
            begin
                if (o_space)
                begin
                    o_load     = 1'b1;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = last_reg ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM:
            begin
                if (o_space)
                begin
                    o_load     = 1'b1;
                    o_byte_n   = 8'd0;
                    o_last_n   = 1'b1;
                    cnt_next   = '0;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid && cmd_head.kind == CMD_BYTE
            && len_reg < LenW'(MaxWordLen))
            word_mem[len_reg[PosW-1:0]] <= cmd_head.data;
        if (store_wr)
        begin
            seen_mem[cnt_reg[IdxW-1:0]] <= cur_word;
            seen_len[cnt_reg[IdxW-1:0]] <= len_reg;
        end
        rd_word_reg <= seen_mem[sidx_reg[IdxW-1:0]];
        rd_len_reg  <= seen_len[sidx_reg[IdxW-1:0]];
        if (o_load)
        begin
            o_byte_reg  <= o_byte_n;
            o_last_reg  <= o_last_n;
            o_trunc_reg <= o_last_n ? 1'b0 : ovf_reg;
            o_full_reg  <= o_last_n ? 1'b0 : full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            cnt_reg     <= '0;
            sidx_reg    <= '0;
            epos_reg    <= '0;
            full_reg    <= 1'b0;
            last_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            sidx_reg  <= sidx_next;
            epos_reg  <= epos_next;
            full_reg  <= full_next;
            last_reg  <= last_next;
            if (o_load)
                o_valid_reg <= 1'b1;
            else if (out_ch.ready)
                o_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid          = o_valid_reg;
    assign out_ch.out_byte       = o_byte_reg;
    assign out_ch.out_last       = o_last_reg;
    assign out_ch.word_truncated = o_trunc_reg;
    assign out_ch.store_full     = o_full_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxWords))
        else $error("store count out of range");
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (o_load && o_last_n) |=> cnt_reg == '0 && len_reg == '0)
        else $error("terminator did not clear message state");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LenW'(MaxWordLen))
        else $error("word length out of range");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> len_reg != '0)
        else $error("emitting an empty word");
`endif

endmodule
